// ----- rtl/jhmp_pkg.sv -----
// ----------------------------------------------------------------------------
// jhmp_pkg
// Shared constants and types for the JPEG header marker parser.
// ----------------------------------------------------------------------------
package jhmp_pkg;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] CODE_SOI  = 8'hD8;
  localparam logic [7:0] CODE_SOF0 = 8'hC0;
  localparam logic [7:0] CODE_SOS  = 8'hDA;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_MARK  = 2'd2,
    ST_EARLY_END = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    PH_START0 = 8'b0000_0001,
    PH_START1 = 8'b0000_0010,
    PH_LEAD   = 8'b0000_0100,
    PH_CODE   = 8'b0000_1000,
    PH_LEN_HI = 8'b0001_0000,
    PH_LEN_LO = 8'b0010_0000,
    PH_BODY   = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [7:0]  component_count;
    logic        sof_seen;
  } result_t;

endpackage

// ----- rtl/jpeg_header_marker_parser.sv -----
// ----------------------------------------------------------------------------
// jpeg_header_marker_parser
// Walks the header of a JPEG file byte by byte and reports the SOF0 geometry.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. The parse state is updated by a single pass of
// logic in the cycle the byte is accepted, and any result lands in an output
// register backed by one skid entry, so bytes keep flowing while a result
// waits; input stalls only when both output entries are full. A result is
// registered into the output register, or into the skid entry when the output
// register is held. At most one result per file: on SOS, a bad start marker, a
// bad marker lead, or when last_byte arrives first. Bytes after a result are
// dropped until last_byte, which resets the parser for the next file.
module jpeg_header_marker_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output jhmp_pkg::status_t     status,
  output logic [15:0]           image_height,
  output logic [15:0]           image_width,
  output logic [7:0]            component_count,
  output logic                  sof_seen
);
  import jhmp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  current_marker, current_marker_next;
  logic [15:0] segment_length, segment_length_next;
  logic [15:0] segment_offset, segment_offset_next;
  logic [15:0] height_reg, height_reg_next;
  logic [15:0] width_reg, width_reg_next;
  logic [7:0]  components_reg, components_reg_next;
  logic        sof_flag, sof_flag_next;

  logic        hit;
  status_t     hit_status;
  logic        in_accept;
  logic        res_valid;
  result_t     res;
  logic [15:0] off_inc;
  logic [15:0] full_length;

  result_t     out_reg;
  result_t     skid_reg;
  logic        skid_valid;
  logic        out_take;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign off_inc   = segment_offset + 16'd1;
  assign full_length = {segment_length[15:8], data_byte};

  always_comb begin
    phase_next          = phase;
    current_marker_next = current_marker;
    segment_length_next = segment_length;
    segment_offset_next = segment_offset;
    height_reg_next     = height_reg;
    width_reg_next      = width_reg;
    components_reg_next = components_reg;
    sof_flag_next       = sof_flag;
    hit                 = 1'b0;
    hit_status          = ST_OK;
    case (phase)
      PH_START0: begin
        if (data_byte != BYTE_FF) begin
          hit = 1'b1;
          hit_status = ST_BAD_START;
        end else begin
          phase_next = PH_START1;
        end
      end
      PH_START1: begin
        if (data_byte != CODE_SOI) begin
          hit = 1'b1;
          hit_status = ST_BAD_START;
        end else begin
          phase_next = PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (data_byte != BYTE_FF) begin
          hit = 1'b1;
          hit_status = ST_BAD_MARK;
        end else begin
          phase_next = PH_CODE;
        end
      end
      PH_CODE: begin
        if (data_byte != BYTE_FF) begin
          current_marker_next = data_byte;
          if (data_byte == CODE_SOS) begin
            hit = 1'b1;
            hit_status = ST_OK;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        segment_length_next = {data_byte, 8'h00};
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        segment_length_next = full_length;
        segment_offset_next = '0;
        phase_next = (full_length <= 16'd2) ? PH_LEAD : PH_BODY;
      end
      PH_BODY: begin
        if (current_marker == CODE_SOF0) begin
          case (segment_offset)
            16'd1: height_reg_next = {data_byte, 8'h00};
            16'd2: height_reg_next = {height_reg[15:8], data_byte};
            16'd3: width_reg_next = {data_byte, 8'h00};
            16'd4: width_reg_next = {width_reg[15:8], data_byte};
            16'd5: begin
              components_reg_next = data_byte;
              sof_flag_next = 1'b1;
            end
            default: ;
          endcase
        end
        segment_offset_next = off_inc;
        if (off_inc >= segment_length - 16'd2) phase_next = PH_LEAD;
      end
      default: phase_next = PH_DONE;
    endcase
    if (hit) phase_next = PH_DONE;

    res_valid = in_accept && (hit || (last_byte && phase != PH_DONE));
    res.status          = hit ? hit_status : ST_EARLY_END;
    res.image_height    = sof_flag_next ? height_reg_next : 16'd0;
    res.image_width     = sof_flag_next ? width_reg_next : 16'd0;
    res.component_count = sof_flag_next ? components_reg_next : 8'd0;
    res.sof_seen        = sof_flag_next;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START0;
      current_marker <= '0;
      segment_length <= '0;
      segment_offset <= '0;
      height_reg     <= '0;
      width_reg      <= '0;
      components_reg <= '0;
      sof_flag       <= 1'b0;
    end else if (in_accept) begin
      if (last_byte) begin
        phase          <= PH_START0;
        current_marker <= '0;
        segment_length <= '0;
        segment_offset <= '0;
        height_reg     <= '0;
        width_reg      <= '0;
        components_reg <= '0;
        sof_flag       <= 1'b0;
      end else begin
        phase          <= phase_next;
        current_marker <= current_marker_next;
        segment_length <= segment_length_next;
        segment_offset <= segment_offset_next;
        height_reg     <= height_reg_next;
        width_reg      <= width_reg_next;
        components_reg <= components_reg_next;
        sof_flag       <= sof_flag_next;
      end
    end
  end

  // output register with skid entry
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !out_take) begin
      if (res_valid) skid_valid <= 1'b1;
    end else begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_reg <= skid_reg;
    end else if (out_valid && !out_take) begin
      if (res_valid) skid_reg <= res;
    end else if (res_valid) begin
      out_reg <= res;
    end
  end

  assign status          = out_reg.status;
  assign image_height    = out_reg.image_height;
  assign image_width     = out_reg.image_width;
  assign component_count = out_reg.component_count;
  assign sof_seen        = out_reg.sof_seen;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_byte |=> phase == PH_START0 && !sof_flag)
    else $error("parser did not restart after the final byte");

  a_no_sof_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sof_seen |-> image_height == 16'd0 && image_width == 16'd0
      && component_count == 8'd0)
    else $error("geometry reported without an SOF0 segment");

  a_one_result_per_file: assert property (@(posedge clk) disable iff (rst)
    in_accept && !last_byte && phase == PH_DONE |-> !res_valid)
    else $error("second result within one file");

endmodule
